### design/smms_pkg.sv
// Package for the source map mapping serializer.
// Holds field widths, tdata layout, character codes, sequencer types and the
// base64 digit table. No dependencies.
package smms_pkg;

    // Default widths of the stored positions.
    localparam int LINE_BITS_DEF   = 24;
    localparam int COLUMN_BITS_DEF = 20;
    localparam int FILE_BITS_DEF   = 16;
    localparam int TYPE_BITS       = 16;

    // Input tdata layout, lowest field first.
    localparam int GL_LSB = 0;
    localparam int GL_W   = 25;
    localparam int GC_LSB = GL_LSB + GL_W;
    localparam int GC_W   = 21;
    localparam int SF_LSB = GC_LSB + GC_W;
    localparam int SF_W   = 17;
    localparam int SL_LSB = SF_LSB + SF_W;
    localparam int SL_W   = 25;
    localparam int SC_LSB = SL_LSB + SL_W;
    localparam int SC_W   = 21;
    localparam int TY_LSB = SC_LSB + SC_W;
    localparam int TY_W   = 16;
    localparam int S_TDATA_W = 128;

    // Output tdata layout.
    localparam int CHAR_W    = 7;
    localparam int REP_W     = 24;
    localparam int M_TDATA_W = 32;

    // Result limits and characters.
    localparam int             MAX_RESULTS = 31;
    localparam int             CNT_W       = 5;
    localparam logic [REP_W-1:0]  REPEAT_MAX = 24'hFF_FFFF;
    localparam logic [CHAR_W-1:0] CH_SEMI    = 7'd59;
    localparam logic [CHAR_W-1:0] CH_COMMA   = 7'd44;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEP,
        ST_DIGIT
    } state_t;

    // Delta fields in output order.
    typedef enum logic [2:0] {
        FLD_GCOL,
        FLD_SFILE,
        FLD_SLINE,
        FLD_SCOL,
        FLD_TYPE
    } field_t;

    // Maps a 6-bit value onto the base64 alphabet A-Z a-z 0-9 + /.
    function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] d);
        logic [CHAR_W-1:0] dx;
        logic [CHAR_W-1:0] ch;
        dx = {1'b0, d};
        if (d < 6'd26) begin
            ch = dx + 7'd65;
        end else if (d < 6'd52) begin
            ch = dx + 7'd71;
        end else if (d < 6'd62) begin
            ch = dx - 7'd4;
        end else if (d == 6'd62) begin
            ch = 7'd43;
        end else begin
            ch = 7'd47;
        end
        return ch;
    endfunction

endpackage

### design/source_map_mapping_serializer.sv
// Source map mapping serializer: turns mappings into separator and base64 VLQ
// characters, one character per cycle at most, none while stalled. Depends on smms_pkg.
// The first character of an item is registered in the separator step when a
// semicolon or comma opens it, and in the first digit step otherwise.
// Each item passes an accept step, a separator step, then a digit step per
// base64 digit; a new item is accepted only when the sequencer is idle again.
// Output back-pressure stretches the separator and digit steps by the stall time.
// Reset (aresetn low, synchronous) empties the output and clears all previous
// positions; the next item is treated as the first of a map.
module source_map_mapping_serializer #(
    parameter int LINE_BITS   = smms_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = smms_pkg::COLUMN_BITS_DEF,
    parameter int FILE_BITS   = smms_pkg::FILE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // generated line, generated column, source file, source line,
    // source column, mapping type (lowest bit first), zero pad to 128
    input  logic [smms_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // first_of_map
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // char_code, repeat_count (lowest bit first), zero pad to 32
    output logic [smms_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tlast
);

    localparam int LW  = LINE_BITS;
    localparam int CW  = COLUMN_BITS;
    localparam int FW  = FILE_BITS;
    localparam int TW  = smms_pkg::TYPE_BITS;
    localparam int M1  = (LW > CW) ? LW : CW;
    localparam int M2  = (FW > TW) ? FW : TW;
    localparam int MW  = (M1 > M2) ? M1 : M2;

    smms_pkg::state_t state_reg, state_next;
    smms_pkg::field_t fld_reg, fld_next;

    logic [LW-1:0] cur_gl_reg, cur_gl_next, prev_gl_reg, prev_gl_next;
    logic [CW-1:0] cur_gc_reg, cur_gc_next, prev_gc_reg, prev_gc_next;
    logic [FW-1:0] cur_sf_reg, cur_sf_next, prev_sf_reg, prev_sf_next;
    logic [LW-1:0] cur_sl_reg, cur_sl_next, prev_sl_reg, prev_sl_next;
    logic [CW-1:0] cur_sc_reg, cur_sc_next, prev_sc_reg, prev_sc_next;
    logic [TW-1:0] cur_ty_reg, cur_ty_next, prev_ty_reg, prev_ty_next;
    logic          at_first_reg, at_first_next;
    logic [MW:0]   shift_reg, shift_next;
    logic [smms_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    logic                        out_valid_reg, out_valid_next;
    logic [smms_pkg::CHAR_W-1:0] out_char_reg, out_char_next;
    logic [smms_pkg::REP_W-1:0]  out_rep_reg, out_rep_next;
    logic                        out_last_reg, out_last_next;

    logic          s_accept;
    logic          adv;
    logic [31:0]   gl_dec, gc_dec, sf_dec, sl_dec, sc_dec;

    // Shared delta unit.
    smms_pkg::field_t prep_fld;
    logic          prep_zero;
    logic [MW-1:0] sel_cur, sel_prev, d_up, d_dn;
    logic          sel_neg;
    logic [MW:0]   prep_v;

    // Digit step.
    logic [MW:0]   rest;
    logic          more;
    logic [5:0]    digit;
    logic          trunc;
    logic          dig_last;

    // Separator step.
    logic [LW-1:0] run;
    logic [31:0]   run32;
    logic          line_up, line_ne;

    assign s_axis_tready = (state_reg == smms_pkg::ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign adv           = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{(smms_pkg::M_TDATA_W - smms_pkg::REP_W - smms_pkg::CHAR_W){1'b0}},
                            out_rep_reg, out_char_reg};

    // Positions arrive 1-based; the decrement wraps within the stored width.
    assign gl_dec = 32'(s_axis_tdata[smms_pkg::GL_LSB +: smms_pkg::GL_W]) - 32'd1;
    assign gc_dec = 32'(s_axis_tdata[smms_pkg::GC_LSB +: smms_pkg::GC_W]) - 32'd1;
    assign sf_dec = 32'(s_axis_tdata[smms_pkg::SF_LSB +: smms_pkg::SF_W]) - 32'd1;
    assign sl_dec = 32'(s_axis_tdata[smms_pkg::SL_LSB +: smms_pkg::SL_W]) - 32'd1;
    assign sc_dec = 32'(s_axis_tdata[smms_pkg::SC_LSB +: smms_pkg::SC_W]) - 32'd1;

    // Line comparison and semicolon run length with saturation.
    assign line_up = cur_gl_reg > prev_gl_reg;
    assign line_ne = cur_gl_reg != prev_gl_reg;
    assign run     = cur_gl_reg - prev_gl_reg;
    assign run32   = 32'(run);

    // Field the delta unit prepares: the column after the separator, else the
    // field that follows the one being shifted out.
    always_comb begin
        prep_fld  = smms_pkg::FLD_GCOL;
        prep_zero = 1'b0;
        case (state_reg)
            smms_pkg::ST_SEP: begin
                prep_zero = line_ne;
            end
            smms_pkg::ST_DIGIT: begin
                case (fld_reg)
                    smms_pkg::FLD_GCOL:  prep_fld = smms_pkg::FLD_SFILE;
                    smms_pkg::FLD_SFILE: prep_fld = smms_pkg::FLD_SLINE;
                    smms_pkg::FLD_SLINE: prep_fld = smms_pkg::FLD_SCOL;
                    default:             prep_fld = smms_pkg::FLD_TYPE;
                endcase
            end
            default: begin
                prep_fld = smms_pkg::FLD_GCOL;
            end
        endcase
    end

    // Delta unit: both differences in parallel, sign in the LSB of the result.
    always_comb begin
        sel_cur  = '0;
        sel_prev = '0;
        case (prep_fld)
            smms_pkg::FLD_GCOL: begin
                sel_cur  = MW'(cur_gc_reg);
                sel_prev = prep_zero ? '0 : MW'(prev_gc_reg);
            end
            smms_pkg::FLD_SFILE: begin
                sel_cur  = MW'(cur_sf_reg);
                sel_prev = MW'(prev_sf_reg);
            end
            smms_pkg::FLD_SLINE: begin
                sel_cur  = MW'(cur_sl_reg);
                sel_prev = MW'(prev_sl_reg);
            end
            smms_pkg::FLD_SCOL: begin
                sel_cur  = MW'(cur_sc_reg);
                sel_prev = MW'(prev_sc_reg);
            end
            smms_pkg::FLD_TYPE: begin
                sel_cur  = MW'(cur_ty_reg);
                sel_prev = MW'(prev_ty_reg);
            end
            default: begin
                sel_cur  = '0;
                sel_prev = '0;
            end
        endcase
        d_up    = sel_cur - sel_prev;
        d_dn    = sel_prev - sel_cur;
        sel_neg = sel_cur < sel_prev;
        prep_v  = {(sel_neg ? d_dn : d_up), sel_neg};
    end

    // One base64 digit per unstalled cycle from the low end of the shift register.
    assign rest     = shift_reg >> 5;
    assign more     = |rest;
    assign digit    = {more, shift_reg[4:0]};
    assign trunc    = (cnt_reg == smms_pkg::CNT_W'(smms_pkg::MAX_RESULTS - 1));
    assign dig_last = trunc || (!more && fld_reg == smms_pkg::FLD_TYPE);

    // Next state and datapath updates.
    always_comb begin
        state_next     = state_reg;
        fld_next       = fld_reg;
        cur_gl_next    = cur_gl_reg;
        cur_gc_next    = cur_gc_reg;
        cur_sf_next    = cur_sf_reg;
        cur_sl_next    = cur_sl_reg;
        cur_sc_next    = cur_sc_reg;
        cur_ty_next    = cur_ty_reg;
        prev_gl_next   = prev_gl_reg;
        prev_gc_next   = prev_gc_reg;
        prev_sf_next   = prev_sf_reg;
        prev_sl_next   = prev_sl_reg;
        prev_sc_next   = prev_sc_reg;
        prev_ty_next   = prev_ty_reg;
        at_first_next  = at_first_reg;
        shift_next     = shift_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_char_next  = out_char_reg;
        out_rep_next   = out_rep_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            smms_pkg::ST_IDLE: begin
                // Capture the item as 0-based positions; a new map clears history.
                if (s_accept) begin
                    cur_gl_next = gl_dec[LW-1:0];
                    cur_gc_next = gc_dec[CW-1:0];
                    cur_sf_next = sf_dec[FW-1:0];
                    cur_sl_next = sl_dec[LW-1:0];
                    cur_sc_next = sc_dec[CW-1:0];
                    cur_ty_next = s_axis_tdata[smms_pkg::TY_LSB +: TW];
                    if (s_axis_tuser) begin
                        prev_gl_next  = '0;
                        prev_gc_next  = '0;
                        prev_sf_next  = '0;
                        prev_sl_next  = '0;
                        prev_sc_next  = '0;
                        prev_ty_next  = '0;
                        at_first_next = 1'b1;
                    end
                    state_next = smms_pkg::ST_SEP;
                end
            end
            smms_pkg::ST_SEP: begin
                // Separator if one is due, then load the generated column delta.
                if (adv) begin
                    cnt_next  = '0;
                    if (line_up) begin
                        out_valid_next = 1'b1;
                        out_char_next  = smms_pkg::CH_SEMI;
                        out_rep_next   = (run32 > 32'(smms_pkg::REPEAT_MAX)) ?
                                         smms_pkg::REPEAT_MAX : run32[smms_pkg::REP_W-1:0];
                        out_last_next  = 1'b0;
                        cnt_next       = smms_pkg::CNT_W'(1);
                        prev_gl_next   = cur_gl_reg;
                    end else if (!line_ne && !at_first_reg) begin
                        out_valid_next = 1'b1;
                        out_char_next  = smms_pkg::CH_COMMA;
                        out_rep_next   = smms_pkg::REP_W'(1);
                        out_last_next  = 1'b0;
                        cnt_next       = smms_pkg::CNT_W'(1);
                    end
                    prev_gc_next  = cur_gc_reg;
                    at_first_next = 1'b0;
                    shift_next    = prep_v;
                    fld_next      = smms_pkg::FLD_GCOL;
                    state_next    = smms_pkg::ST_DIGIT;
                end
            end
            smms_pkg::ST_DIGIT: begin
                // Emit one digit; at a field's end load the next, or idle after type or if full.
                if (adv) begin
                    out_valid_next = 1'b1;
                    out_char_next  = smms_pkg::b64_char(digit);
                    out_rep_next   = smms_pkg::REP_W'(1);
                    out_last_next  = dig_last;
                    cnt_next       = cnt_reg + smms_pkg::CNT_W'(1);
                    if (trunc) begin
                        // Output is full; the history still takes the whole item.
                        prev_gc_next = cur_gc_reg;
                        prev_sf_next = cur_sf_reg;
                        prev_sl_next = cur_sl_reg;
                        prev_sc_next = cur_sc_reg;
                        prev_ty_next = cur_ty_reg;
                        state_next   = smms_pkg::ST_IDLE;
                    end else if (more) begin
                        shift_next = rest;
                    end else if (fld_reg == smms_pkg::FLD_TYPE) begin
                        state_next = smms_pkg::ST_IDLE;
                    end else begin
                        fld_next   = prep_fld;
                        shift_next = prep_v;
                        case (prep_fld)
                            smms_pkg::FLD_SFILE: prev_sf_next = cur_sf_reg;
                            smms_pkg::FLD_SLINE: prev_sl_next = cur_sl_reg;
                            smms_pkg::FLD_SCOL:  prev_sc_next = cur_sc_reg;
                            default:             prev_ty_next = cur_ty_reg;
                        endcase
                    end
                end
            end
            default: begin
                state_next = smms_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and history registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= smms_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            at_first_reg  <= 1'b1;
            prev_gl_reg   <= '0;
            prev_gc_reg   <= '0;
            prev_sf_reg   <= '0;
            prev_sl_reg   <= '0;
            prev_sc_reg   <= '0;
            prev_ty_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            at_first_reg  <= at_first_next;
            prev_gl_reg   <= prev_gl_next;
            prev_gc_reg   <= prev_gc_next;
            prev_sf_reg   <= prev_sf_next;
            prev_sl_reg   <= prev_sl_next;
            prev_sc_reg   <= prev_sc_next;
            prev_ty_reg   <= prev_ty_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        fld_reg      <= fld_next;
        cur_gl_reg   <= cur_gl_next;
        cur_gc_reg   <= cur_gc_next;
        cur_sf_reg   <= cur_sf_next;
        cur_sl_reg   <= cur_sl_next;
        cur_sc_reg   <= cur_sc_next;
        cur_ty_reg   <= cur_ty_next;
        shift_reg    <= shift_next;
        cnt_reg      <= cnt_next;
        out_char_reg <= out_char_next;
        out_rep_reg  <= out_rep_next;
        out_last_reg <= out_last_next;
    end

    // An accepted item always goes to the separator step next.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == smms_pkg::ST_SEP)
        else $error("accepted item did not start the separator step");

    // The last character of an item returns the sequencer to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == smms_pkg::ST_DIGIT && adv && dig_last) |=>
            state_reg == smms_pkg::ST_IDLE && out_valid_reg && out_last_reg)
        else $error("last character did not end the item");

    // Only a semicolon carries a repeat count other than one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_char_reg != smms_pkg::CH_SEMI) |->
            out_rep_reg == smms_pkg::REP_W'(1))
        else $error("repeat count above one on a non-semicolon character");

    // A semicolon run is never empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_char_reg == smms_pkg::CH_SEMI) |-> out_rep_reg != '0)
        else $error("empty semicolon run");

    // The result count never passes the limit while digits are emitted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == smms_pkg::ST_DIGIT |->
            cnt_reg < smms_pkg::CNT_W'(smms_pkg::MAX_RESULTS))
        else $error("result count overflow");

endmodule
